// ----- rtl/adeg_pkg.sv -----
// Shared types and constants for the attack-decay envelope generator.
// No dependencies; every other file in rtl/ imports this package.
package adeg_pkg;

  localparam int RATE_W     = 26;
  localparam int LEVEL_W    = 24;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 2;

  // Full scale of the elapsed-time accumulator (Q2.24) and of the level (Q1.23).
  localparam logic [RATE_W-1:0]  ONE_Q24     = 26'd16777216;
  localparam logic [RATE_W-1:0]  ELAPSED_MAX = 26'h3FFFFFF;
  localparam logic [LEVEL_W-1:0] ONE_Q23     = 24'd8388608;

  localparam logic [RATE_W-1:0]  ATTACK_RATE_RST    = 26'd33554432;
  localparam logic [RATE_W-1:0]  DECAY_RATE_RST     = 26'd33554432;
  localparam logic [LEVEL_W-1:0] DECAY_FACTOR_RST   = 24'd0;
  localparam logic               ATTACK_ALLOWED_RST = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ATTACK = 2'd1,
    PH_DECAY  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_RATE    = 2'd0,
    REG_DECAY_RATE     = 2'd1,
    REG_DECAY_FACTOR   = 2'd2,
    REG_ATTACK_ALLOWED = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [RATE_W-1:0]  attack_rate;
    logic [RATE_W-1:0]  decay_rate;
    logic [LEVEL_W-1:0] decay_factor;
    logic               attack_allowed;
  } cfg_regs_t;

endpackage

// ----- rtl/adeg_cfg_regs.sv -----
// Configuration register file for the envelope generator.
// Depends on adeg_pkg for the register index codes and the register struct.
module adeg_cfg_regs
  import adeg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        REG_ATTACK_RATE:    cfg_nxt.attack_rate    = wr_data[RATE_W-1:0];
        REG_DECAY_RATE:     cfg_nxt.decay_rate     = wr_data[RATE_W-1:0];
        REG_DECAY_FACTOR:   cfg_nxt.decay_factor   = wr_data[LEVEL_W-1:0];
        REG_ATTACK_ALLOWED: cfg_nxt.attack_allowed = wr_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_rate    <= ATTACK_RATE_RST;
      cfg_r.decay_rate     <= DECAY_RATE_RST;
      cfg_r.decay_factor   <= DECAY_FACTOR_RST;
      cfg_r.attack_allowed <= ATTACK_ALLOWED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/adeg_step.sv -----
// Envelope state and the per-sample update: edge detect, phase control,
// saturating elapsed-time accumulator and one shared multiplier. Uses adeg_pkg.
module adeg_step
  import adeg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               gate_on,
  input  logic               trigger_on,
  input  cfg_regs_t          cfg,
  output logic [LEVEL_W-1:0] level_nxt
);

  localparam int PROD_W = LEVEL_W + LEVEL_W + 1;

  phase_t             phase_r,       phase_nxt;
  logic [RATE_W-1:0]  elapsed_r,     elapsed_nxt;
  logic [LEVEL_W-1:0] start_level_r, start_level_nxt;
  logic [LEVEL_W-1:0] env_level_r;
  logic               gate_before_r, trigger_before_r;

  logic               edge_hit;
  phase_t             phase_act;
  logic [RATE_W-1:0]  el_start;
  logic [RATE_W-1:0]  rate_sel;
  logic [RATE_W:0]    el_sum;
  logic [RATE_W-1:0]  el_acc;
  logic               el_done;
  logic [LEVEL_W:0]   mul_a;
  logic [LEVEL_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  att_rnd;
  logic [PROD_W-1:0]  dec_rnd;
  logic [LEVEL_W:0]   att_lv;
  logic [LEVEL_W+1:0] dec_lv;

  always_comb begin
    edge_hit  = (trigger_on && !trigger_before_r) || (gate_on && !gate_before_r);
    phase_act = (edge_hit && cfg.attack_allowed) ? PH_ATTACK : phase_r;
    el_start  = edge_hit ? '0 : elapsed_r;

    // The start level is recaptured whenever the timer sits at zero.
    if (el_start == '0) begin
      start_level_nxt = (env_level_r > ONE_Q23) ? ONE_Q23 : env_level_r;
    end else begin
      start_level_nxt = start_level_r;
    end

    rate_sel = (phase_act == PH_ATTACK) ? cfg.attack_rate : cfg.decay_rate;
    el_sum   = {1'b0, el_start} + {1'b0, rate_sel};
    el_acc   = el_sum[RATE_W] ? ELAPSED_MAX : el_sum[RATE_W-1:0];
    el_done  = el_acc > ONE_Q24;

    // One multiplier serves both the attack ramp and the decay product.
    if (phase_act == PH_ATTACK) begin
      mul_a = el_acc[LEVEL_W:0];
      mul_b = ONE_Q23 - start_level_nxt;
    end else begin
      mul_a = {1'b0, env_level_r};
      mul_b = cfg.decay_factor;
    end
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    att_rnd = prod + (PROD_W'(1) << 23);
    dec_rnd = prod + (PROD_W'(1) << 22);
    att_lv  = {1'b0, start_level_nxt} + att_rnd[LEVEL_W+24:24];
    dec_lv  = dec_rnd[LEVEL_W+24:23];
  end

  always_comb begin
    phase_nxt   = phase_act;
    elapsed_nxt = el_start;
    level_nxt   = '0;
    unique case (phase_act)
      PH_ATTACK: begin
        if (el_done) begin
          phase_nxt   = PH_DECAY;
          level_nxt   = ONE_Q23;
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = el_acc;
          level_nxt   = (att_lv > {1'b0, ONE_Q23}) ? ONE_Q23 : att_lv[LEVEL_W-1:0];
        end
      end
      PH_DECAY: begin
        if (el_done) begin
          phase_nxt   = PH_IDLE;
          level_nxt   = '0;
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = el_acc;
          level_nxt   = (dec_lv > {2'b00, ONE_Q23}) ? ONE_Q23 : dec_lv[LEVEL_W-1:0];
        end
      end
      default: begin
        level_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      elapsed_r        <= '0;
      start_level_r    <= '0;
      env_level_r      <= '0;
      gate_before_r    <= 1'b0;
      trigger_before_r <= 1'b0;
    end else if (fire) begin
      phase_r          <= phase_nxt;
      elapsed_r        <= elapsed_nxt;
      start_level_r    <= start_level_nxt;
      env_level_r      <= level_nxt;
      gate_before_r    <= gate_on;
      trigger_before_r <= trigger_on;
    end
  end

endmodule

// ----- rtl/ad_envelope_generator_core.sv -----
// An input transfer is captured in the stage-1 registers; its result is written
// to the output register once that register is empty or its transfer completes.
// Throughput: one sample per cycle while out_stall is low; the envelope update
// is combinational through a single 25x24 multiplier, input to output register.
// Reset (rst_n, synchronous): envelope idle at zero, both pipeline stages empty,
// configuration registers at their default values.
module ad_envelope_generator_core
  import adeg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_gate_on,
  input  logic                  in_trigger_on,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_env_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t          cfg;
  logic               s1_valid_r;
  logic               s1_gate_r;
  logic               s1_trigger_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_env_r;
  logic [LEVEL_W-1:0] level_nxt;
  logic               advance;
  logic               fire;
  logic               in_xfer;

  assign cfg_ready = 1'b1;

  adeg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // The output register frees up when it is empty or its transfer completes.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  adeg_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .gate_on    (s1_gate_r),
    .trigger_on (s1_trigger_r),
    .cfg        (cfg),
    .level_nxt  (level_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_gate_r    <= in_gate_on;
      s1_trigger_r <= in_trigger_on;
    end
    if (fire) begin
      out_env_r <= level_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_env_out = out_env_r;

endmodule

// ----- dv/tb_ad_envelope_generator_core.sv -----
// Self-checking testbench for ad_envelope_generator_core: directed envelope cases, then
// random gate/trigger patterns over several register settings, with random backpressure.
// Depends on adeg_pkg and the core RTL only.
module tb_ad_envelope_generator_core;
  import adeg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 80;
  localparam int RANDOM_PHASES  = 9;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_gate_on = 1'b0;
  logic                  in_trigger_on = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVEL_W-1:0]    out_env_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ATTACK_RATE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted register contents and envelope state.
  cfg_regs_t          cfg_shadow;
  phase_t             env_phase;
  logic [RATE_W-1:0]  env_elapsed;
  logic [LEVEL_W-1:0] env_start;
  logic [LEVEL_W-1:0] env_level;
  logic               gate_prev;
  logic               trig_prev;

  logic [LEVEL_W-1:0] expected_levels[$];
  logic [LEVEL_W-1:0] level_due;
  int                 mismatch_count = 0;
  int                 idle_pct = 30;
  int                 quiet_cycles = 0;

  ad_envelope_generator_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_gate_on   (in_gate_on),
    .in_trigger_on(in_trigger_on),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_env_out  (out_env_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the predicted envelope by one sample and returns its level.
  function automatic logic [LEVEL_W-1:0] advance_envelope(input logic g, input logic t);
    logic [RATE_W:0] sum;
    logic [63:0]     prod;
    logic [63:0]     lv;
    if ((t && !trig_prev) || (g && !gate_prev)) begin
      if (cfg_shadow.attack_allowed) env_phase = PH_ATTACK;
      env_elapsed = '0;
    end
    if (env_elapsed == '0) env_start = (env_level > ONE_Q23) ? ONE_Q23 : env_level;
    case (env_phase)
      PH_ATTACK: begin
        sum = {1'b0, env_elapsed} + {1'b0, cfg_shadow.attack_rate};
        env_elapsed = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[RATE_W-1:0];
        if (env_elapsed > ONE_Q24) begin
          env_phase   = PH_DECAY;
          env_level   = ONE_Q23;
          env_elapsed = '0;
        end else begin
          prod = 64'(env_elapsed) * 64'(ONE_Q23 - env_start);
          lv = 64'(env_start) + ((prod + 64'd8388608) >> 24);
          env_level = (lv > 64'(ONE_Q23)) ? ONE_Q23 : lv[LEVEL_W-1:0];
        end
      end
      PH_DECAY: begin
        sum = {1'b0, env_elapsed} + {1'b0, cfg_shadow.decay_rate};
        env_elapsed = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[RATE_W-1:0];
        if (env_elapsed > ONE_Q24) begin
          env_phase   = PH_IDLE;
          env_level   = '0;
          env_elapsed = '0;
        end else begin
          prod = 64'(env_level) * 64'(cfg_shadow.decay_factor);
          lv = (prod + 64'd4194304) >> 23;
          env_level = (lv > 64'(ONE_Q23)) ? ONE_Q23 : lv[LEVEL_W-1:0];
        end
      end
      default: env_level = '0;
    endcase
    gate_prev = g;
    trig_prev = t;
    return env_level;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // in_valid is left high so back-to-back samples need no extra assignment.
  task automatic send_sample(input logic g, input logic t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid      <= 1'b0;
      in_gate_on    <= 1'($urandom_range(1));
      in_trigger_on <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_gate_on    <= g;
    in_trigger_on <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_levels.push_back(advance_envelope(g, t));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high; set_config lowers it after the last write.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ATTACK_RATE:    cfg_shadow.attack_rate    = data;
      REG_DECAY_RATE:     cfg_shadow.decay_rate     = data;
      REG_DECAY_FACTOR:   cfg_shadow.decay_factor   = data[LEVEL_W-1:0];
      REG_ATTACK_ALLOWED: cfg_shadow.attack_allowed = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] attack_rate,
                            input logic [CFG_DATA_W-1:0] decay_rate,
                            input logic [CFG_DATA_W-1:0] decay_factor,
                            input logic [CFG_DATA_W-1:0] attack_allowed);
    wait_drained();
    write_reg(REG_ATTACK_RATE, attack_rate);
    write_reg(REG_DECAY_RATE, decay_rate);
    write_reg(REG_DECAY_FACTOR, decay_factor);
    write_reg(REG_ATTACK_ALLOWED, attack_allowed);
    cfg_valid <= 1'b0;
  endtask

  // Power-on settings: a rising edge jumps straight to full scale, then to idle.
  task automatic test_default_config();
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
  endtask

  // Quarter-step attack and decay, then a trigger edge in mid-decay that ramps
  // up again from the captured level.
  task automatic test_attack_decay_shape();
    set_config(ONE_Q24 / 4, ONE_Q24 / 4, 26'd6291456, 26'd1);
    repeat (7) send_sample(1'b1, 1'b0);
    repeat (2) send_sample(1'b1, 1'b1);
  endtask

  // With a zero rate the elapsed time never moves: decay runs forever and an
  // attack holds the level where it was.
  task automatic test_zero_rates();
    set_config(26'd33554432, 26'd0, 26'd7340032, 26'd1);
    send_sample(1'b0, 1'b0);
    repeat (2) send_sample(1'b1, 1'b0);
    set_config(26'd0, 26'd0, 26'd7340032, 26'd1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
  endtask

  // A decay factor above one must clamp the level at full scale.
  task automatic test_factor_above_one();
    set_config(26'd33554432, ONE_Q24 / 8, 26'hFFFFFF, 26'd1);
    send_sample(1'b0, 1'b0);
    repeat (3) send_sample(1'b0, 1'b1);
  endtask

  // With attack disallowed an edge only restarts the decay timing.
  task automatic test_attack_disallowed();
    set_config(ONE_Q24 / 2, ONE_Q24 / 4, 26'd8388608, 26'd0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
  endtask

  // Largest rates: the elapsed-time sum must saturate rather than wrap.
  task automatic test_rate_saturation();
    set_config(26'h3FFFFFF, 26'h3FFFFFF, 26'd8388608, 26'd1);
    send_sample(1'b0, 1'b0);
    repeat (2) send_sample(1'b1, 1'b0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 26'd33554432;
      2:       return 26'h3FFFFFF;
      3:       return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'(ONE_Q24 / $urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_factor();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ONE_Q23;
      2:       return 24'hFFFFFF;
      3:       return LEVEL_W'($urandom());
      default: return LEVEL_W'($urandom_range(6291456, 8388608));
    endcase
  endfunction

  // Mostly note-like patterns (rise, hold, release) with random lengths, mixed
  // with sample-by-sample noise. One phase runs with no idling on either side.
  task automatic test_random_notes();
    int         n;
    int         hold_len;
    int         rest_len;
    logic [1:0] lvl;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_config(pick_rate(), pick_rate(),
                 {2'($urandom_range(3)), pick_factor()},
                 {25'($urandom()), 1'($urandom_range(3) != 0)});
      idle_pct = (ph == 4) ? 0 : 30;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          lvl      = 2'($urandom_range(1, 3));
          hold_len = $urandom_range(1, 40);
          rest_len = $urandom_range(0, 20);
          repeat (hold_len) send_sample(lvl[1], lvl[0]);
          repeat (rest_len) send_sample(1'b0, 1'b0);
          n += hold_len + rest_len;
        end else begin
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
          n++;
        end
      end
    end
    idle_pct = 30;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $error("env_out: expected no transfer, actual %0d", out_env_out);
        mismatch_count++;
      end else begin
        level_due = expected_levels.pop_front();
        if (out_env_out !== level_due) begin
          $error("env_out: expected %0d, actual %0d", level_due, out_env_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_shadow  = '{attack_rate: ATTACK_RATE_RST, decay_rate: DECAY_RATE_RST,
                    decay_factor: DECAY_FACTOR_RST, attack_allowed: ATTACK_ALLOWED_RST};
    env_phase   = PH_IDLE;
    env_elapsed = '0;
    env_start   = '0;
    env_level   = '0;
    gate_prev   = 1'b0;
    trig_prev   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_attack_decay_shape();
    test_zero_rates();
    test_factor_above_one();
    test_attack_disallowed();
    test_rate_saturation();
    test_random_notes();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
